// ----- rtl/cms_pkg.sv -----
// Shared constants, types and state codes for the centroid motion smoother.
package cms_pkg;

    // Default elaboration limits
    localparam int MAX_WIDTH_DEF     = 2048;
    localparam int MAX_HEIGHT_DEF    = 2048;
    localparam int HISTORY_DEPTH_DEF = 10;

    // Field and accumulator widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int WSUM_W    = 42;
    localparam int ISUM_W    = 30;
    localparam int CEN_W     = 11;
    localparam int DELTA_W   = 12;

    // Depth of the frame queue and of the result queue
    localparam int QUEUE_DEPTH = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // Sums of one finished frame, handed from front to back
    typedef struct packed {
        logic [WSUM_W-1:0] wcol;
        logic [WSUM_W-1:0] wrow;
        logic [ISUM_W-1:0] isum;
    } t_snapshot;

    // One result item
    typedef struct packed {
        logic [CEN_W-1:0]          cx;
        logic [CEN_W-1:0]          cy;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [DELTA_W-1:0] sx;
        logic signed [DELTA_W-1:0] sy;
    } t_result;

    // Request to the shared divider
    typedef struct packed {
        logic              start;
        logic [WSUM_W-1:0] dividend;
        logic [ISUM_W-1:0] divisor;
    } t_div_req;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_DELTA,
        ST_RING,
        ST_SMOOTH_GO,
        ST_SMOOTH_X,
        ST_SMOOTH_Y,
        ST_PUSH
    } t_back_state;

endpackage

// ----- rtl/centroid_motion_smoother.sv -----
// Top level of the centroid motion smoother.
//
// Pixels enter one per clock in raster order through push/full, while full
// is low, and are accumulated by the front end into column-weighted,
// row-weighted and plain intensity sums; the last pixel of a frame hands the
// three sums to a two-entry frame queue and the front end then carries on
// with the next frame. The back end takes one frame at a time from that
// queue and runs it through one shared restoring divider that yields one
// quotient bit per cycle: centroid x, centroid y, then the two smoothed
// deltas; the centroid divisions are skipped when the frame's intensity sum
// is zero. full rises only while the frame queue holds two finished frames;
// until then the input takes one pixel per cycle without a stall. Results
// wait in a two-entry result queue read through empty/pop; while it is full
// the back end holds its finished result and then the frame queue fills.
// The motion deltas live in a HISTORY_DEPTH-entry RAM with a fill count and
// running sums, so reset needs no clearing pass. Write frame_width and
// frame_height only while the block is idle; a zero size acts as one and a
// size above MAX_WIDTH or MAX_HEIGHT acts as that limit.
module centroid_motion_smoother #(
    parameter int MAX_WIDTH     = cms_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = cms_pkg::MAX_HEIGHT_DEF,
    parameter int HISTORY_DEPTH = cms_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [cms_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cms_pkg::CFG_W-1:0]           i_cfg_data,
    // pixel side
    input  logic                                push,
    output logic                                full,
    input  logic [cms_pkg::PIX_W-1:0]           i_pixel_value,
    // result side
    output logic                                empty,
    input  logic                                pop,
    output logic [cms_pkg::CEN_W-1:0]           o_centroid_x,
    output logic [cms_pkg::CEN_W-1:0]           o_centroid_y,
    output logic signed [cms_pkg::DELTA_W-1:0]  o_motion_dx,
    output logic signed [cms_pkg::DELTA_W-1:0]  o_motion_dy,
    output logic signed [cms_pkg::DELTA_W-1:0]  o_smooth_dx,
    output logic signed [cms_pkg::DELTA_W-1:0]  o_smooth_dy
);

    cms_pkg::t_snapshot front_snap, back_snap;
    cms_pkg::t_result   back_res, out_res;
    logic               snap_push, snap_pop, snap_full, snap_empty;
    logic               res_push, res_full;

    // Front end: take pixels whenever the frame queue has room
    cms_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_pixel_value (i_pixel_value),
        .i_q_full      (snap_full),
        .o_snap_push   (snap_push),
        .o_snap        (front_snap)
    );

    // Frame queue: decouple pixel intake from the per-frame arithmetic
    cms_fifo #(
        .WIDTH ($bits(cms_pkg::t_snapshot)),
        .DEPTH (cms_pkg::QUEUE_DEPTH)
    ) u_snap_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (snap_push),
        .i_data  (front_snap),
        .i_pop   (snap_pop),
        .o_data  (back_snap),
        .o_full  (snap_full),
        .o_empty (snap_empty)
    );

    cms_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (!snap_empty),
        .i_snap       (back_snap),
        .o_snap_pop   (snap_pop),
        .i_out_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (back_res)
    );

    // Result queue: hold finished results until the consumer transfers them
    cms_fifo #(
        .WIDTH ($bits(cms_pkg::t_result)),
        .DEPTH (cms_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign full         = snap_full;
    assign o_centroid_x = out_res.cx;
    assign o_centroid_y = out_res.cy;
    assign o_motion_dx  = out_res.dx;
    assign o_motion_dy  = out_res.dy;
    assign o_smooth_dx  = out_res.sx;
    assign o_smooth_dy  = out_res.sy;

endmodule

// ----- rtl/cms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cms_fifo.sv -----
// Small flop-based queue used between front and back and on the result side.
module cms_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/cms_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module cms_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cms_pkg::t_div_req            i_req,
    output logic                         o_done,
    output logic [cms_pkg::WSUM_W-1:0]   o_quot
);

    localparam int N_W   = cms_pkg::WSUM_W;
    localparam int D_W   = cms_pkg::ISUM_W;
    localparam int CNT_W = $clog2(N_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N_W - 1);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   r_quot;
    logic [D_W-1:0]   r_rem, r_div;
    logic [D_W:0]     trial, diff;
    logic             ge;

    always_comb begin
        trial = {r_rem, r_quot[N_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_div  <= i_req.divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
            r_quot <= {r_quot[N_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/cms_front.sv -----
// Front end: frame size registers, raster counters and per-frame accumulators.
module cms_front #(
    parameter int MAX_WIDTH  = cms_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cms_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cms_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cms_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_push,
    input  logic [cms_pkg::PIX_W-1:0]       i_pixel_value,
    input  logic                            i_q_full,
    output logic                            o_snap_push,
    output cms_pkg::t_snapshot              o_snap
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int LIMC_W = (COL_W + 1 > cms_pkg::CFG_W) ? COL_W + 1 : cms_pkg::CFG_W;
    localparam int LIMR_W = (ROW_W + 1 > cms_pkg::CFG_W) ? ROW_W + 1 : cms_pkg::CFG_W;
    localparam logic [LIMC_W-1:0] MAXC = LIMC_W'(MAX_WIDTH);
    localparam logic [LIMR_W-1:0] MAXR = LIMR_W'(MAX_HEIGHT);

    logic [cms_pkg::CFG_W-1:0]  r_frame_width, r_frame_height;
    logic [COL_W-1:0]           r_col;
    logic [ROW_W-1:0]           r_row;
    logic [cms_pkg::WSUM_W-1:0] r_wcol, r_wrow, n_wcol, n_wrow;
    logic [cms_pkg::ISUM_W-1:0] r_isum, n_isum;

    logic [LIMC_W-1:0] w_ext, w_lim, last_col;
    logic [LIMR_W-1:0] h_ext, h_lim, last_row;
    logic              accept, col_end, row_end, frame_end;
    logic [COL_W+cms_pkg::PIX_W-1:0] col_prod;
    logic [ROW_W+cms_pkg::PIX_W-1:0] row_prod;

    always_comb begin
        // Clamp the frame size: zero acts as one, above the limit acts as the limit
        w_ext = LIMC_W'(r_frame_width);
        h_ext = LIMR_W'(r_frame_height);
        if (w_ext == '0) begin
            w_lim = LIMC_W'(1);
        end else if (w_ext > MAXC) begin
            w_lim = MAXC;
        end else begin
            w_lim = w_ext;
        end
        if (h_ext == '0) begin
            h_lim = LIMR_W'(1);
        end else if (h_ext > MAXR) begin
            h_lim = MAXR;
        end else begin
            h_lim = h_ext;
        end
        last_col = w_lim - 1'b1;
        last_row = h_lim - 1'b1;

        col_end   = (LIMC_W'(r_col) >= last_col);
        row_end   = (LIMR_W'(r_row) >= last_row);
        accept    = i_push && !i_q_full;
        frame_end = accept && col_end && row_end;

        col_prod = COL_W'(r_col) * i_pixel_value;
        row_prod = ROW_W'(r_row) * i_pixel_value;
        n_wcol   = r_wcol + cms_pkg::WSUM_W'(col_prod);
        n_wrow   = r_wrow + cms_pkg::WSUM_W'(row_prod);
        n_isum   = r_isum + cms_pkg::ISUM_W'(i_pixel_value);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= cms_pkg::FRAME_WIDTH_RST;
            r_frame_height <= cms_pkg::FRAME_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
            r_wcol         <= '0;
            r_wrow         <= '0;
            r_isum         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cms_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    cms_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                if (frame_end) begin
                    r_wcol <= '0;
                    r_wrow <= '0;
                    r_isum <= '0;
                end else begin
                    r_wcol <= n_wcol;
                    r_wrow <= n_wrow;
                    r_isum <= n_isum;
                end
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    assign o_snap_push = frame_end;
    assign o_snap.wcol = n_wcol;
    assign o_snap.wrow = n_wrow;
    assign o_snap.isum = n_isum;

endmodule

// ----- rtl/cms_back.sv -----
// Back end: centroid division, motion delta, history ring and smoothing.
module cms_back #(
    parameter int HISTORY_DEPTH = cms_pkg::HISTORY_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_snap_valid,
    input  cms_pkg::t_snapshot i_snap,
    output logic               o_snap_pop,
    input  logic               i_out_full,
    output logic               o_res_push,
    output cms_pkg::t_result   o_res
);

    localparam int DW    = cms_pkg::DELTA_W;
    localparam int CW    = cms_pkg::CEN_W;
    localparam int FR_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int POS_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W = DW + $clog2(HISTORY_DEPTH + 1);
    localparam logic [FR_W-1:0]  FR_FULL  = FR_W'(HISTORY_DEPTH);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(HISTORY_DEPTH - 1);

    cms_pkg::t_back_state r_state, n_state;
    cms_pkg::t_div_req    div_req;
    logic                       div_done;
    logic [cms_pkg::WSUM_W-1:0] div_quot;

    logic [cms_pkg::WSUM_W-1:0] r_wrow;
    logic [cms_pkg::ISUM_W-1:0] r_isum;
    logic [CW-1:0]              r_cx, r_cy, r_prev_cx, r_prev_cy;
    logic                       r_have_prev;
    logic signed [DW-1:0]       r_dx, r_dy, r_sx, r_sy;
    logic [FR_W-1:0]            r_frames, r_fill;
    logic [POS_W-1:0]           r_pos;
    logic signed [SUM_W-1:0]    r_sum_x, r_sum_y;

    logic                       ram_we;
    logic [2*DW-1:0]            ram_rdata;
    logic signed [DW-1:0]       old_x, old_y;
    logic [SUM_W-1:0]           mag_x, mag_y;
    logic [DW-1:0]              q_lo;

    cms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Ring entry holds {dx, dy}; entries past the fill count read as zero
    cms_ram #(
        .WIDTH (2 * DW),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata ({r_dx, r_dy}),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        old_x = (r_fill == FR_FULL) ? ram_rdata[2*DW-1:DW] : '0;
        old_y = (r_fill == FR_FULL) ? ram_rdata[DW-1:0] : '0;
        mag_x = r_sum_x[SUM_W-1] ? SUM_W'(~r_sum_x + 1'b1) : SUM_W'(r_sum_x);
        mag_y = r_sum_y[SUM_W-1] ? SUM_W'(~r_sum_y + 1'b1) : SUM_W'(r_sum_y);
        q_lo  = div_quot[DW-1:0];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cms_pkg::ST_IDLE: begin
                if (i_snap_valid) begin
                    n_state = (i_snap.isum != '0) ? cms_pkg::ST_DIV_X : cms_pkg::ST_DELTA;
                end
            end
            cms_pkg::ST_DIV_X:     if (div_done) n_state = cms_pkg::ST_DIV_Y;
            cms_pkg::ST_DIV_Y:     if (div_done) n_state = cms_pkg::ST_DELTA;
            cms_pkg::ST_DELTA: begin
                n_state = r_have_prev ? cms_pkg::ST_RING : cms_pkg::ST_SMOOTH_GO;
            end
            cms_pkg::ST_RING:      n_state = cms_pkg::ST_SMOOTH_GO;
            cms_pkg::ST_SMOOTH_GO: n_state = cms_pkg::ST_SMOOTH_X;
            cms_pkg::ST_SMOOTH_X:  if (div_done) n_state = cms_pkg::ST_SMOOTH_Y;
            cms_pkg::ST_SMOOTH_Y:  if (div_done) n_state = cms_pkg::ST_PUSH;
            cms_pkg::ST_PUSH:      if (!i_out_full) n_state = cms_pkg::ST_IDLE;
            default:               n_state = cms_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        div_req    = '0;
        o_snap_pop = 1'b0;
        ram_we     = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            cms_pkg::ST_IDLE: begin
                o_snap_pop = i_snap_valid;
                if (i_snap_valid && (i_snap.isum != '0)) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = i_snap.wcol;
                    div_req.divisor  = i_snap.isum;
                end
            end
            cms_pkg::ST_DIV_X: begin
                if (div_done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = r_wrow;
                    div_req.divisor  = r_isum;
                end
            end
            cms_pkg::ST_RING: ram_we = 1'b1;
            cms_pkg::ST_SMOOTH_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = cms_pkg::WSUM_W'(mag_x);
                div_req.divisor  = cms_pkg::ISUM_W'(r_frames);
            end
            cms_pkg::ST_SMOOTH_X: begin
                if (div_done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = cms_pkg::WSUM_W'(mag_y);
                    div_req.divisor  = cms_pkg::ISUM_W'(r_frames);
                end
            end
            cms_pkg::ST_PUSH: o_res_push = !i_out_full;
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cms_pkg::ST_IDLE;
            r_have_prev <= 1'b0;
            r_frames    <= '0;
            r_fill      <= '0;
            r_pos       <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_prev_cx   <= '0;
            r_prev_cy   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == cms_pkg::ST_DELTA) begin
                if (r_frames != FR_FULL) begin
                    r_frames <= r_frames + 1'b1;
                end
                r_have_prev <= 1'b1;
                r_prev_cx   <= r_cx;
                r_prev_cy   <= r_cy;
            end
            if (r_state == cms_pkg::ST_RING) begin
                // Add the new delta, drop the one it overwrites
                r_sum_x <= r_sum_x + SUM_W'(r_dx) - SUM_W'(old_x);
                r_sum_y <= r_sum_y + SUM_W'(r_dy) - SUM_W'(old_y);
                r_pos   <= (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
                if (r_fill != FR_FULL) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            cms_pkg::ST_IDLE: begin
                r_wrow <= i_snap.wrow;
                r_isum <= i_snap.isum;
                r_cx   <= '0;
                r_cy   <= '0;
            end
            cms_pkg::ST_DIV_X: if (div_done) r_cx <= div_quot[CW-1:0];
            cms_pkg::ST_DIV_Y: if (div_done) r_cy <= div_quot[CW-1:0];
            cms_pkg::ST_DELTA: begin
                if (r_have_prev) begin
                    r_dx <= DW'({1'b0, r_cx}) - DW'({1'b0, r_prev_cx});
                    r_dy <= DW'({1'b0, r_cy}) - DW'({1'b0, r_prev_cy});
                end else begin
                    r_dx <= '0;
                    r_dy <= '0;
                end
            end
            cms_pkg::ST_SMOOTH_X: begin
                if (div_done) begin
                    r_sx <= r_sum_x[SUM_W-1] ? DW'(~q_lo + 1'b1) : q_lo;
                end
            end
            cms_pkg::ST_SMOOTH_Y: begin
                if (div_done) begin
                    r_sy <= r_sum_y[SUM_W-1] ? DW'(~q_lo + 1'b1) : q_lo;
                end
            end
            default: ;
        endcase
    end

    assign o_res.cx = r_cx;
    assign o_res.cy = r_cy;
    assign o_res.dx = r_dx;
    assign o_res.dy = r_dy;
    assign o_res.sx = r_sx;
    assign o_res.sy = r_sy;

endmodule

// ----- rtl/cms_checker.sv -----
// Port-level checks for the centroid motion smoother, bound to the top level.
module cms_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                push,
    input logic                                full,
    input logic                                empty,
    input logic                                pop,
    input logic [cms_pkg::CEN_W-1:0]           o_centroid_x,
    input logic [cms_pkg::CEN_W-1:0]           o_centroid_y,
    input logic signed [cms_pkg::DELTA_W-1:0]  o_motion_dx,
    input logic signed [cms_pkg::DELTA_W-1:0]  o_motion_dy,
    input logic signed [cms_pkg::DELTA_W-1:0]  o_smooth_dx,
    input logic signed [cms_pkg::DELTA_W-1:0]  o_smooth_dy
);

    localparam logic [cms_pkg::DELTA_W-1:0] DELTA_MIN = {1'b1, {(cms_pkg::DELTA_W-1){1'b0}}};

    // Reset leaves both queues drained
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not drained after reset");

    // A waiting result holds until it is transferred
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_centroid_x) && $stable(o_centroid_y)
            && $stable(o_motion_dx) && $stable(o_motion_dy)
            && $stable(o_smooth_dx) && $stable(o_smooth_dy)))
        else $error("waiting result changed before transfer");

    // Deltas and their averages stay within the span of an 11-bit centroid
    a_delta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_motion_dx != DELTA_MIN && o_motion_dy != DELTA_MIN
            && o_smooth_dx != DELTA_MIN && o_smooth_dy != DELTA_MIN))
        else $error("delta out of range");

    // The frame queue cannot fill without pixels coming in
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("intake stalled without a pixel transfer");

endmodule

bind centroid_motion_smoother cms_checker u_cms_checker (.*);
